/* hw/rtl/drsr_pkg.sv */
// Shared types, constants and helpers for the dueling RRIP replacement unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package drsr_pkg;

  // Cache geometry and policy sizes.
  localparam int NUM_SETS      = 2048;
  localparam int NUM_WAYS      = 16;
  localparam int SIG_W         = 6;
  localparam int SEL_W         = 10;
  localparam int LEADER_STRIDE = 32;
  localparam int LEADER_GROUPS = 64;

  localparam int SET_W    = $clog2(NUM_SETS);
  localparam int WAY_W    = $clog2(NUM_WAYS);
  localparam int STRIDE_W = $clog2(LEADER_STRIDE);
  localparam int GROUP_W  = SET_W - STRIDE_W;
  localparam int SIG_COUNT = 1 << SIG_W;

  localparam logic [1:0] RRPV_MAX  = 2'd3;
  localparam logic [1:0] REUSE_MAX = 2'd3;
  localparam logic [1:0] REUSE_HOT = REUSE_MAX / 2'd2;
  localparam logic [1:0] REUSE_RESET = 2'd1;
  localparam logic [SEL_W-1:0] SEL_MAX   = {SEL_W{1'b1}};
  localparam logic [SEL_W-1:0] SEL_RESET = SEL_MAX >> 1;

  // Operation codes.
  localparam logic [1:0] OP_VICTIM = 2'd0;
  localparam logic [1:0] OP_HIT    = 2'd1;
  localparam logic [1:0] OP_FILL   = 2'd2;

  // Input transaction layout on s_tdata.
  localparam int OP_LSB   = 0;
  localparam int SET_LSB  = 2;
  localparam int WAY_LSB  = 13;
  localparam int PC_LSB   = 17;
  localparam int DRAW_LSB = 81;
  localparam int IN_W     = 88;

  // Output transaction layout on m_tdata.
  localparam int VICTIM_LSB = 0;
  localparam int SELV_LSB   = 4;
  localparam int OUT_W      = 16;

  typedef logic [NUM_WAYS-1:0][1:0]       rrpv_row_t;
  typedef logic [NUM_WAYS-1:0][SIG_W-1:0] sig_row_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic lookup;
    logic update;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
  } status_t;

  // Folds a 64-bit program counter into a signature.
  function automatic logic [SIG_W-1:0] sig_hash(input logic [63:0] pc);
    return pc[SIG_W-1:0] ^ pc[2*SIG_W-1:SIG_W] ^ pc[3*SIG_W-1:2*SIG_W];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/drsr_ctrl.sv */
// Sequencing controller of the replacement unit: clearing pass, per-item steps
// and the output valid flag. Depends on drsr_pkg.
`default_nettype none

module drsr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output drsr_pkg::cmd_t         cmd,
  input  wire drsr_pkg::status_t status
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  state_t state;
  state_t state_next;
  logic   m_tvalid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        // The write-back waits until the output register is free.
        if (!m_tvalid || m_tready) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.update) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/drsr_datapath.sv */
// Datapath of the replacement unit: line state memories, reuse counter memory,
// dueling selector, victim search and the output register. Depends on drsr_pkg.
`default_nettype none

module drsr_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire drsr_pkg::cmd_t             cmd,
  output drsr_pkg::status_t               status,
  input  wire logic [drsr_pkg::IN_W-1:0]  in_data,
  output logic [drsr_pkg::OUT_W-1:0]      out_data
);

  localparam logic [1:0] KIND_FOLLOW = 2'd0;
  localparam logic [1:0] KIND_LIP    = 2'd1;
  localparam logic [1:0] KIND_BIP    = 2'd2;

  // Line state, one row per set.
  drsr_pkg::rrpv_row_t rrpv_mem [drsr_pkg::NUM_SETS];
  drsr_pkg::sig_row_t  sig_mem  [drsr_pkg::NUM_SETS];
  logic [1:0]          reuse_mem [drsr_pkg::SIG_COUNT];

  logic [drsr_pkg::SET_W-1:0] clear_cnt;

  logic [1:0]                 op_q;
  logic [drsr_pkg::SET_W-1:0] set_q;
  logic [drsr_pkg::WAY_W-1:0] way_q;
  logic [drsr_pkg::SIG_W-1:0] sig_q;
  logic [4:0]                 draw_q;

  drsr_pkg::rrpv_row_t rrpv_row_q;
  drsr_pkg::sig_row_t  sig_row_q;
  logic [1:0]          reuse_old_q;
  logic [1:0]          reuse_new_q;

  logic [drsr_pkg::SEL_W-1:0] selector;
  logic [drsr_pkg::SEL_W-1:0] selector_next;

  logic [drsr_pkg::SIG_W-1:0] old_sig;
  logic [drsr_pkg::GROUP_W-1:0] group;
  logic [drsr_pkg::STRIDE_W-1:0] offset;
  logic [1:0]                 kind;
  logic                       way_ok;

  logic                       has_max;
  logic                       has_near;
  logic [drsr_pkg::WAY_W-1:0] first_max;
  logic [drsr_pkg::WAY_W-1:0] first_near;
  logic [drsr_pkg::WAY_W-1:0] victim;

  drsr_pkg::rrpv_row_t rrpv_row_new;
  drsr_pkg::sig_row_t  sig_row_new;
  logic [1:0]          reuse_wdata;
  logic [drsr_pkg::SIG_W-1:0] reuse_waddr;
  logic                reuse_we;
  logic [1:0]          old_dec;
  logic [1:0]          new_eff;
  logic                bip;
  logic [1:0]          ins;
  logic [drsr_pkg::SET_W-1:0] row_waddr;
  logic                row_we;

  assign status.clear_last = (clear_cnt == drsr_pkg::SET_W'(drsr_pkg::NUM_SETS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt <= '0;
    end else if (cmd.clear_step && !status.clear_last) begin
      clear_cnt <= clear_cnt + 1'b1;
    end
  end

  // Capture the input transaction.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= in_data[drsr_pkg::OP_LSB +: 2];
      set_q  <= in_data[drsr_pkg::SET_LSB +: drsr_pkg::SET_W];
      way_q  <= in_data[drsr_pkg::WAY_LSB +: drsr_pkg::WAY_W];
      sig_q  <= drsr_pkg::sig_hash(in_data[drsr_pkg::PC_LSB +: 64]);
      draw_q <= in_data[drsr_pkg::DRAW_LSB +: 5];
    end
  end

  // Set classification for dueling.
  always_comb begin
    group  = set_q[drsr_pkg::SET_W-1:drsr_pkg::STRIDE_W];
    offset = set_q[drsr_pkg::STRIDE_W-1:0];
    kind   = KIND_FOLLOW;
    if (int'(group) < drsr_pkg::LEADER_GROUPS) begin
      if (offset == '0) begin
        kind = KIND_LIP;
      end else if (offset == drsr_pkg::STRIDE_W'(drsr_pkg::LEADER_STRIDE / 2)) begin
        kind = KIND_BIP;
      end
    end
  end

  assign way_ok  = (int'(way_q) < drsr_pkg::NUM_WAYS);
  assign old_sig = sig_row_q[way_q];

  // Victim search: first way at the maximum, or after one aging step the
  // first way that was one below it.
  always_comb begin
    has_max    = 1'b0;
    has_near   = 1'b0;
    first_max  = '0;
    first_near = '0;
    for (int w = drsr_pkg::NUM_WAYS - 1; w >= 0; w--) begin
      if (rrpv_row_q[w] == drsr_pkg::RRPV_MAX) begin
        has_max   = 1'b1;
        first_max = drsr_pkg::WAY_W'(w);
      end
      if (rrpv_row_q[w] == drsr_pkg::RRPV_MAX - 2'd1) begin
        has_near   = 1'b1;
        first_near = drsr_pkg::WAY_W'(w);
      end
    end
  end

  always_comb begin
    rrpv_row_new  = rrpv_row_q;
    sig_row_new   = sig_row_q;
    selector_next = selector;
    victim        = '0;
    reuse_we      = 1'b0;
    reuse_waddr   = sig_q;
    reuse_wdata   = reuse_new_q;
    old_dec       = (reuse_old_q != 2'd0) ? reuse_old_q - 2'd1 : 2'd0;
    new_eff       = (old_sig == sig_q) ? old_dec : reuse_new_q;
    bip           = 1'b0;
    ins           = drsr_pkg::RRPV_MAX;
    case (op_q)
      drsr_pkg::OP_VICTIM: begin
        if (has_max) begin
          victim = first_max;
        end else begin
          for (int w = 0; w < drsr_pkg::NUM_WAYS; w++) begin
            rrpv_row_new[w] = rrpv_row_q[w] + 2'd1;
          end
          victim = has_near ? first_near : '0;
        end
      end
      drsr_pkg::OP_HIT: begin
        if (way_ok) begin
          rrpv_row_new[way_q] = 2'd0;
          sig_row_new[way_q]  = sig_q;
          reuse_we    = 1'b1;
          reuse_waddr = sig_q;
          reuse_wdata = (reuse_new_q < drsr_pkg::REUSE_MAX) ? reuse_new_q + 2'd1 : reuse_new_q;
          if (kind == KIND_LIP && selector < drsr_pkg::SEL_MAX) begin
            selector_next = selector + 1'b1;
          end else if (kind == KIND_BIP && selector != '0) begin
            selector_next = selector - 1'b1;
          end
        end
      end
      drsr_pkg::OP_FILL: begin
        if (way_ok) begin
          reuse_we    = 1'b1;
          reuse_waddr = old_sig;
          reuse_wdata = old_dec;
          if (kind == KIND_LIP) begin
            bip = 1'b0;
          end else if (kind == KIND_BIP) begin
            bip = 1'b1;
          end else begin
            bip = (selector < drsr_pkg::SEL_RESET);
          end
          if ((bip && draw_q == 5'd0) || new_eff >= drsr_pkg::REUSE_HOT) begin
            ins = 2'd0;
          end
          rrpv_row_new[way_q] = ins;
          sig_row_new[way_q]  = sig_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign row_we    = cmd.clear_step || cmd.update;
  assign row_waddr = cmd.clear_step ? clear_cnt : set_q;

  always_ff @(posedge clk) begin
    if (row_we) begin
      rrpv_mem[row_waddr] <= cmd.clear_step ? {drsr_pkg::NUM_WAYS{drsr_pkg::RRPV_MAX}}
                                            : rrpv_row_new;
    end
    if (cmd.capture) begin
      rrpv_row_q <= rrpv_mem[in_data[drsr_pkg::SET_LSB +: drsr_pkg::SET_W]];
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      sig_mem[row_waddr] <= cmd.clear_step ? '0 : sig_row_new;
    end
    if (cmd.capture) begin
      sig_row_q <= sig_mem[in_data[drsr_pkg::SET_LSB +: drsr_pkg::SET_W]];
    end
  end

  // Reuse counters: two reads in the lookup step, one write at update.
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      reuse_mem[clear_cnt[drsr_pkg::SIG_W-1:0]] <= drsr_pkg::REUSE_RESET;
    end else if (cmd.update && reuse_we) begin
      reuse_mem[reuse_waddr] <= reuse_wdata;
    end
    if (cmd.lookup) begin
      reuse_old_q <= reuse_mem[old_sig];
      reuse_new_q <= reuse_mem[sig_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selector <= drsr_pkg::SEL_RESET;
    end else if (cmd.update) begin
      selector <= selector_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_data <= {{(drsr_pkg::OUT_W - drsr_pkg::SEL_W - drsr_pkg::WAY_W){1'b0}},
                   selector_next, victim};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dueling_rrip_signature_replacement_unit.sv */
// Dueling RRIP replacement unit with PC-signature reuse prediction: takes
// victim requests, hit updates and fill updates as stream transactions and
// returns one result transaction for each, carrying the victim way and the
// dueling selector. After reset a clearing pass over all 2048 sets initializes
// the line state and reuse counters, and no input is taken until it ends.
// Each item then goes through a set row read, a reuse counter read and a
// write-back. The reuse counter of the evicted line can only be addressed
// once its stored signature has come back from the set row read, so the two
// reads follow one another before the write-back. A new item is taken in the
// cycle after the write-back, and the write-back waits while the previous
// result is still held on the output.
// Depends on drsr_pkg, drsr_ctrl and drsr_datapath.
`default_nettype none

module dueling_rrip_signature_replacement_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // operation[1:0], set_index[12:2], way_index[16:13], pc[80:17],
  // random_draw[85:81], zero fill [87:86]
  input  wire logic [drsr_pkg::IN_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // victim_way[3:0], selector_value[13:4], zero fill [15:14]
  output logic [drsr_pkg::OUT_W-1:0]     m_tdata
);

  drsr_pkg::cmd_t    cmd;
  drsr_pkg::status_t status;

  drsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  drsr_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_data  (s_tdata),
    .out_data (m_tdata)
  );

endmodule

`default_nettype wire

/* tb/tb_dueling_rrip_signature_replacement_unit.sv */
// Self-checking testbench for the dueling RRIP replacement unit: victim, hit and fill
// transactions are checked against a behavioral predictor of line and selector state.
// Depends on drsr_pkg and dueling_rrip_signature_replacement_unit.
`default_nettype none

module tb_dueling_rrip_signature_replacement_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import drsr_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 9;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 20;
  localparam longint TIMEOUT_CYCLES = 300_000;
  localparam int PUSH_CAP        = 900;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [4:0]       draw;
    logic [63:0]      pc;
    logic [WAY_W-1:0] way;
    logic [SET_W-1:0] set_idx;
    logic [1:0]       op;
  } access_t;

  typedef struct packed {
    logic [SEL_W-1:0] selector;
    logic [WAY_W-1:0] victim;
  } replacement_result_t;

  typedef enum logic [1:0] {FOLLOWER_SET, LIP_LEADER_SET, BIP_LEADER_SET} set_role_e;
  typedef enum logic [1:0] {TRAFFIC_MIXED, TRAFFIC_LIP_HITS, TRAFFIC_BIP_HITS} traffic_mode_e;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;

  // Predicted replacement state.
  logic [1:0]       rrpv_store [NUM_SETS*NUM_WAYS];
  logic [SIG_W-1:0] sig_store  [NUM_SETS*NUM_WAYS];
  logic [1:0]       reuse_ctr  [SIG_COUNT];
  logic [SEL_W-1:0] duel_sel;

  replacement_result_t pending_results [$];
  logic [WAY_W-1:0]    last_victim;
  logic [63:0]         pc_pool [8];
  int unsigned         hot_sets [8];
  int unsigned         mismatch_count = 0;
  logic                tx_idle_en = 1'b0;
  logic                rx_idle_en = 1'b0;
  logic                hold_off_req = 1'b0;

  dueling_rrip_signature_replacement_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("tb_dueling_rrip_signature_replacement_unit: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [SIG_W-1:0] fold_pc(input logic [63:0] pc);
    logic [63:0] folded;
    folded = pc ^ (pc >> SIG_W) ^ (pc >> (2 * SIG_W));
    return folded[SIG_W-1:0];
  endfunction

  function automatic set_role_e role_of(input logic [SET_W-1:0] set_idx);
    int unsigned group;
    int unsigned offset;
    group  = set_idx / LEADER_STRIDE;
    offset = set_idx % LEADER_STRIDE;
    if (group >= LEADER_GROUPS) return FOLLOWER_SET;
    if (offset == 0) return LIP_LEADER_SET;
    if (offset == LEADER_STRIDE / 2) return BIP_LEADER_SET;
    return FOLLOWER_SET;
  endfunction

  // Returns the first distant line; if there is none the whole set ages once and the
  // search repeats, falling back to way zero.
  function automatic logic [WAY_W-1:0] pick_victim(input int unsigned base);
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (rrpv_store[base + w] == RRPV_MAX) return WAY_W'(w);
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (rrpv_store[base + w] != RRPV_MAX) rrpv_store[base + w]++;
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (rrpv_store[base + w] == RRPV_MAX) return WAY_W'(w);
    end
    return '0;
  endfunction

  function automatic replacement_result_t predict_access(input access_t a);
    replacement_result_t r;
    int unsigned         base;
    int unsigned         idx;
    logic [SIG_W-1:0]    sig;
    logic [SIG_W-1:0]    old_sig;
    set_role_e           role;
    logic                use_bip;
    logic [1:0]          insert_rrpv;
    r.victim = '0;
    base = (a.set_idx % NUM_SETS) * NUM_WAYS;
    idx  = base + a.way;
    sig  = fold_pc(a.pc);
    role = role_of(a.set_idx);
    case (a.op)
      OP_VICTIM: begin
        r.victim = pick_victim(base);
      end
      OP_HIT: begin
        rrpv_store[idx] = '0;
        sig_store[idx]  = sig;
        if (reuse_ctr[sig] < REUSE_MAX) reuse_ctr[sig]++;
        if (role == LIP_LEADER_SET && duel_sel != SEL_MAX) duel_sel++;
        else if (role == BIP_LEADER_SET && duel_sel != '0) duel_sel--;
      end
      OP_FILL: begin
        old_sig = sig_store[idx];
        if (reuse_ctr[old_sig] != '0) reuse_ctr[old_sig]--;
        use_bip = (role == BIP_LEADER_SET) || (role == FOLLOWER_SET && duel_sel < SEL_RESET);
        insert_rrpv = RRPV_MAX;
        if (use_bip && a.draw == '0) insert_rrpv = '0;
        // A signature with observed reuse overrides the insertion policy.
        if (reuse_ctr[sig] >= REUSE_HOT) insert_rrpv = '0;
        rrpv_store[idx] = insert_rrpv;
        sig_store[idx]  = sig;
      end
      default: begin
      end
    endcase
    r.selector = duel_sel;
    return r;
  endfunction

  task automatic init_model();
    for (int i = 0; i < NUM_SETS * NUM_WAYS; i++) begin
      rrpv_store[i] = RRPV_MAX;
      sig_store[i]  = '0;
    end
    for (int i = 0; i < SIG_COUNT; i++) reuse_ctr[i] = REUSE_RESET;
    duel_sel = SEL_RESET;
    pc_pool[0] = '0;
    pc_pool[1] = '1;
    for (int i = 2; i < 8; i++) pc_pool[i] = {$urandom, $urandom};
    hot_sets = '{0, 16, 2016, 2032, 5, 2047, 0, 0};
    hot_sets[6] = $urandom_range(0, NUM_SETS - 1);
    hot_sets[7] = $urandom_range(0, NUM_SETS - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic send_access(input access_t a);
    replacement_result_t r;
    s_tdata  <= IN_W'(a);
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_access(a);
    last_victim = r.victim;
    pending_results.push_back(r);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic issue(input logic [1:0] op, input int unsigned set_idx,
                       input int unsigned way, input logic [63:0] pc,
                       input int unsigned draw);
    access_t a;
    a.op      = op;
    a.set_idx = SET_W'(set_idx);
    a.way     = WAY_W'(way);
    a.pc      = pc;
    a.draw    = 5'(draw);
    send_access(a);
  endtask

  function automatic logic [63:0] pick_pc();
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    return pc_pool[$urandom_range(0, 7)];
  endfunction

  function automatic int unsigned pick_draw();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 31);
  endfunction

  function automatic int unsigned pick_set();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, NUM_SETS - 1);
    return hot_sets[$urandom_range(0, 7)];
  endfunction

  // One step of cache-like traffic: a victim request followed by a fill of the chosen
  // way, a hit, a stray fill, or noise. Push modes mostly hit leader sets of one kind.
  task automatic traffic_step(input traffic_mode_e mode);
    int unsigned pick;
    int unsigned set_idx;
    logic [95:0] noise;
    pick = $urandom_range(0, 99);
    if (mode != TRAFFIC_MIXED && pick < 98) begin
      set_idx = $urandom_range(0, LEADER_GROUPS - 1) * LEADER_STRIDE
              + ((mode == TRAFFIC_BIP_HITS) ? LEADER_STRIDE / 2 : 0);
      issue(OP_HIT, set_idx, $urandom_range(0, NUM_WAYS - 1), pick_pc(), pick_draw());
    end else begin
      set_idx = pick_set();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        issue(OP_VICTIM, set_idx, $urandom_range(0, NUM_WAYS - 1), pick_pc(), pick_draw());
        issue(OP_FILL, set_idx, last_victim, pick_pc(), pick_draw());
      end else if (pick < 70) begin
        issue(OP_HIT, set_idx, $urandom_range(0, NUM_WAYS - 1), pick_pc(), pick_draw());
      end else if (pick < 90) begin
        issue(OP_FILL, set_idx, $urandom_range(0, NUM_WAYS - 1), pick_pc(), pick_draw());
      end else if (pick < 95) begin
        issue(OP_NONE, set_idx, $urandom_range(0, NUM_WAYS - 1), pick_pc(), pick_draw());
      end else begin
        noise = {$urandom, $urandom, $urandom};
        send_access(access_t'(noise[$bits(access_t)-1:0]));
      end
    end
  endtask

  task automatic test_reset_state();
    issue(OP_VICTIM, 0, 0, '0, 0);
    issue(OP_NONE, NUM_SETS - 1, NUM_WAYS - 1, '1, 31);
  endtask

  task automatic test_insertion_policy();
    issue(OP_FILL, 0, 0, '0, 31);                     // cold signature in an LIP leader
    issue(OP_HIT, 2016, NUM_WAYS - 1, '1, 31);        // LIP leader raises the selector
    issue(OP_HIT, 2032, 3, 64'hA5A5_0F0F_3C3C_9696, 0);
    issue(OP_FILL, 16, 1, '0, 0);                     // BIP leader, zero draw
    issue(OP_FILL, NUM_SETS - 1, 4, '0, 0);           // follower at the selector midpoint
    issue(OP_FILL, NUM_SETS - 1, 9, '1, 17);          // reused signature goes to MRU
  endtask

  // Drives a set through both fallbacks of the victim search, then a search that
  // succeeds only after aging on a way other than zero.
  task automatic test_victim_aging();
    for (int w = 0; w < NUM_WAYS; w++) issue(OP_HIT, 5, w, pc_pool[w % 8], w);
    issue(OP_VICTIM, 5, 0, '0, 0);
    issue(OP_VICTIM, 5, 0, '0, 0);
    issue(OP_HIT, 5, 0, pc_pool[3], 0);
    issue(OP_VICTIM, 5, 0, '0, 0);
  endtask

  task automatic test_mixed_traffic();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (40) traffic_step(TRAFFIC_MIXED);
  endtask

  task automatic test_output_backpressure();
    hold_off_req <= 1'b1;
    repeat (20) traffic_step(TRAFFIC_MIXED);
  endtask

  task automatic test_selector_saturation();
    int unsigned n;
    n = 0;
    while (duel_sel != SEL_MAX && n < PUSH_CAP) begin
      traffic_step(TRAFFIC_LIP_HITS);
      n++;
    end
    repeat (15) traffic_step(TRAFFIC_LIP_HITS);
  endtask

  // Brings the selector back under its midpoint so followers insert bimodally.
  task automatic test_follower_bimodal();
    int unsigned n;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    n = 0;
    while (duel_sel >= SEL_RESET && n < PUSH_CAP) begin
      traffic_step(TRAFFIC_BIP_HITS);
      n++;
    end
    repeat (30) traffic_step(TRAFFIC_MIXED);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and result checking
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_tready     <= 1'b0;
        hold_off_req <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    replacement_result_t want;
    logic [WAY_W-1:0]    got_victim;
    logic [SEL_W-1:0]    got_sel;
    if (!rst && m_tvalid && m_tready) begin
      got_victim = m_tdata[VICTIM_LSB +: WAY_W];
      got_sel    = m_tdata[SELV_LSB +: SEL_W];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result transaction victim %0d selector %0d",
                   $realtime, got_victim, got_sel);
      end else begin
        want = pending_results.pop_front();
        if (got_victim !== want.victim || got_sel !== want.selector) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: expected victim %0d selector %0d, got victim %0d selector %0d",
                     $realtime, want.victim, want.selector, got_victim, got_sel);
        end
      end
    end
  end

  initial begin
    init_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_insertion_policy();
    test_victim_aging();
    test_mixed_traffic();
    test_output_backpressure();
    test_selector_saturation();
    test_follower_bimodal();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_dueling_rrip_signature_replacement_unit: PASS");
    end else begin
      $display("tb_dueling_rrip_signature_replacement_unit: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/drsr_pkg.sv
hw/rtl/drsr_ctrl.sv
hw/rtl/drsr_datapath.sv
hw/rtl/dueling_rrip_signature_replacement_unit.sv
tb/tb_dueling_rrip_signature_replacement_unit.sv
